FILE: rtl/core/mjd_to_calendar_date_unit_defines.svh
// Assertion macros for the MJD to calendar date unit.
// Both macros expect clk and rst in the calling scope.
`ifndef MJD_TO_CALENDAR_DATE_UNIT_DEFINES_SVH
`define MJD_TO_CALENDAR_DATE_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define MJDCAL_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mjdcal: same-cycle check failed");
`define MJDCAL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mjdcal: next-cycle check failed");
`else
`define MJDCAL_ASSERT_NOW(lbl, ante, cons)
`define MJDCAL_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

FILE: rtl/core/mjdcal_pkg.sv
`default_nettype none
package mjdcal_pkg;

  localparam int PIPE_DEPTH = 25;

  localparam logic signed [22:0] MJD_FIRST_VALID = -23'sd678575;
  localparam logic signed [22:0] MJD_LAST_VALID  = 23'sd2973483;

  // floor(x / D) ~ (x * RCP) >> SH, one low at most, then one correction
  localparam int DIV_B  = 146097;
  localparam int RCP_B  = 114;
  localparam int SH_B   = 24;
  localparam int DIV_D  = 1461;
  localparam int RCP_D  = 22966;
  localparam int SH_D   = 25;
  localparam int DIV_F  = 306001;
  localparam int RCP_F  = 27;
  localparam int SH_F   = 23;
  localparam int DIV_DD = 10000;
  localparam int RCP_DD = 838;
  localparam int SH_DD  = 23;
  localparam int DIV_C  = 100;
  localparam int RCP_C  = 163;
  localparam int SH_C   = 14;

  typedef struct packed {
    logic [PIPE_DEPTH-1:0] en;
    logic [PIPE_DEPTH-1:0] valid;
  } pipe_ctl_t;

  typedef struct packed {
    logic signed [22:0] mjd;
    logic               rerr;
    logic [24:0]        xw;
    logic [14:0]        qe;
    logic [25:0]        prod;
    logic [7:0]         b;
    logic [22:0]        c;
    logic [13:0]        d;
    logic [22:0]        e;
    logic [9:0]         g;
    logic [3:0]         f;
    logic [4:0]         dd;
    logic [3:0]         m;
    logic [13:0]        y;
    logic [13:0]        yb;
    logic [24:0]        j1;
    logic [7:0]         q100;
    logic [7:0]         k;
    logic [8:0]         n;
  } date_t;

  typedef struct packed {
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [31:0] res;
    logic [21:0] sec;
  } tod_t;

endpackage
`default_nettype wire

FILE: rtl/core/mjdcal_if.sv
`default_nettype none
interface mjdcal_in_if;
  logic               valid;
  logic               ready;
  logic signed [22:0] mjd_day;
  logic [31:0]        day_fraction;

  modport source (output valid, output mjd_day, output day_fraction, input ready);
  modport sink (input valid, input mjd_day, input day_fraction, output ready);
endinterface

interface mjdcal_out_if;
  logic        valid;
  logic        ready;
  logic [13:0] year_out;
  logic [3:0]  month_out;
  logic [4:0]  day_of_month;
  logic [8:0]  day_in_year;
  logic [4:0]  hour_out;
  logic [5:0]  minute_out;
  logic [21:0] second_fixed;
  logic        range_error;

  modport source (output valid, output year_out, output month_out, output day_of_month,
                  output day_in_year, output hour_out, output minute_out,
                  output second_fixed, output range_error, input ready);
  modport sink (input valid, input year_out, input month_out, input day_of_month,
                input day_in_year, input hour_out, input minute_out,
                input second_fixed, input range_error, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/mjdcal_ctl.sv
`default_nettype none
module mjdcal_ctl
  import mjdcal_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  input  wire logic out_ready,
  output pipe_ctl_t ctl
);

  logic [PIPE_DEPTH-1:0] valid;
  logic [PIPE_DEPTH-1:0] en;

  // a stage may load unless it and every stage after it are full and the output stalls
  always_comb begin
    for (int k = 0; k < PIPE_DEPTH; k++) begin
      en[k] = out_ready | ~(&(valid | ~({PIPE_DEPTH{1'b1}} << k)));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (en[0]) begin
        valid[0] <= in_valid;
      end
      for (int k = 1; k < PIPE_DEPTH; k++) begin
        if (en[k]) begin
          valid[k] <= valid[k-1];
        end
      end
    end
  end

  assign ctl.en    = en;
  assign ctl.valid = valid;

endmodule
`default_nettype wire

FILE: rtl/core/mjdcal_date.sv
`default_nettype none
module mjdcal_date
  import mjdcal_pkg::*;
(
  input  wire logic               clk,
  input  wire pipe_ctl_t          ctl,
  input  wire logic signed [22:0] mjd_day,
  output logic [13:0]             year_out,
  output logic [3:0]              month_out,
  output logic [4:0]              day_of_month,
  output logic [8:0]              day_in_year,
  output logic                    range_error
);

  date_t st [PIPE_DEPTH];
  date_t st_next [PIPE_DEPTH];

  always_comb begin
    logic [25:0] t26;
    logic [39:0] m40;
    logic [24:0] rem;
    logic [7:0]  qb;
    logic [7:0]  bs;
    logic [14:0] q;

    st_next[0]      = '0;
    st_next[0].mjd  = mjd_day;
    st_next[0].rerr = (mjd_day < MJD_FIRST_VALID) || (mjd_day > MJD_LAST_VALID);
    // 4*jd0 - 7468865 biased up by 4*146097 so the quotient stays non-negative
    t26 = {mjd_day[22], mjd_day, 2'b00} + 26'd2715527;
    st_next[0].xw = t26[24:0];

    for (int k = 1; k < PIPE_DEPTH; k++) begin
      st_next[k] = st[k-1];
    end

    // b = floor((4*jd0 - 7468865) / 146097)
    m40 = 40'(st[0].xw) * 40'(RCP_B);
    st_next[1].qe = 15'(m40 >> SH_B);
    st_next[2].prod = 26'(32'(st[1].qe) * 32'(DIV_B));
    rem = st[2].xw - st[2].prod[24:0];
    qb = st[2].qe[7:0] + {7'd0, rem >= 25'(DIV_B)};
    st_next[3].b = qb - 8'd4;

    // c = jd0 + b - floor(b/4) + 1402, then d = floor((4c + 3) / 1461)
    bs = {{2{st[3].b[7]}}, st[3].b[7:2]};
    t26 = {{3{st[3].mjd[22]}}, st[3].mjd} + {{18{st[3].b[7]}}, st[3].b}
          - {{18{bs[7]}}, bs} + 26'd2401403;
    st_next[4].c  = t26[22:0];
    st_next[4].xw = {t26[22:0], 2'b11};
    m40 = 40'(st[4].xw) * 40'(RCP_D);
    st_next[5].qe = 15'(m40 >> SH_D);
    st_next[6].prod = 26'(32'(st[5].qe) * 32'(DIV_D));
    rem = st[6].xw - st[6].prod[24:0];
    st_next[7].d = 14'(st[6].qe + {14'd0, rem >= 25'(DIV_D)});

    // e = 365d + floor(d/4), g = c - e + 123
    st_next[8].e = 23'(32'(st[7].d) * 32'd365 + 32'(st[7].d >> 2));
    st_next[9].g = 10'(st[8].c - st[8].e + 23'd123);

    // f = floor(10000g / 306001)
    st_next[10].xw = 25'(32'(st[9].g) * 32'(DIV_DD));
    m40 = 40'(st[10].xw) * 40'(RCP_F);
    st_next[11].qe = 15'(m40 >> SH_F);
    st_next[12].prod = 26'(32'(st[11].qe) * 32'(DIV_F));
    rem = st[12].xw - st[12].prod[24:0];
    st_next[13].f = 4'(st[12].qe + {14'd0, rem >= 25'(DIV_F)});

    // day = g - floor(306001f / 10000), month from f
    st_next[14].xw = 25'(32'(st[13].f) * 32'(DIV_F));
    m40 = 40'(st[14].xw) * 40'(RCP_DD);
    st_next[15].qe = 15'(m40 >> SH_DD);
    st_next[16].prod = 26'(32'(st[15].qe) * 32'(DIV_DD));
    rem = st[16].xw - st[16].prod[24:0];
    q = st[16].qe + {14'd0, rem >= 25'(DIV_DD)};
    st_next[17].dd = 5'(st[16].g - q[9:0]);
    st_next[17].m  = (st[16].f >= 4'd14) ? st[16].f - 4'd13 : st[16].f - 4'd1;

    st_next[18].y = st[17].d - 14'd4716 + {13'd0, st[17].m < 4'd3};

    // January first of y, from the day number formula
    st_next[19].xw = 25'(st[18].y) + 25'd4799;
    st_next[19].yb = st[18].y + 14'd4899;
    st_next[20].j1 = 25'(32'(st[19].xw) * 32'(DIV_D));
    m40 = 40'(st[19].yb) * 40'(RCP_C);
    st_next[20].qe = 15'(m40 >> SH_C);
    st_next[21].prod = 26'(32'(st[20].qe) * 32'(DIV_C));
    st_next[22].q100 = 8'(st[21].qe
                          + {14'd0, (st[21].yb - st[21].prod[13:0]) >= 14'(DIV_C)});
    st_next[23].k = 8'((10'(st[22].q100) * 10'd3) >> 2);
    t26 = {{3{st[23].mjd[22]}}, st[23].mjd} - 26'(st[23].j1 >> 2)
          + 26'(st[23].k) + 26'd2431740;
    st_next[24].n = t26[8:0];
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < PIPE_DEPTH; k++) begin
      if (ctl.en[k]) begin
        st[k] <= st_next[k];
      end
    end
  end

  assign range_error  = st[PIPE_DEPTH-1].rerr;
  assign year_out     = st[PIPE_DEPTH-1].rerr ? '0 : st[PIPE_DEPTH-1].y;
  assign month_out    = st[PIPE_DEPTH-1].rerr ? '0 : st[PIPE_DEPTH-1].m;
  assign day_of_month = st[PIPE_DEPTH-1].rerr ? '0 : st[PIPE_DEPTH-1].dd;
  assign day_in_year  = st[PIPE_DEPTH-1].rerr ? '0 : st[PIPE_DEPTH-1].n;

endmodule
`default_nettype wire

FILE: rtl/core/mjdcal_tod.sv
`default_nettype none
module mjdcal_tod
  import mjdcal_pkg::*;
(
  input  wire logic      clk,
  input  wire pipe_ctl_t ctl,
  input  wire logic [31:0] day_fraction,
  output logic [4:0]     hour_out,
  output logic [5:0]     minute_out,
  output logic [21:0]    second_fixed
);

  tod_t st [PIPE_DEPTH];
  tod_t st_next [PIPE_DEPTH];

  always_comb begin
    logic [36:0] m37;
    logic [37:0] m38;

    m37 = 37'(day_fraction) * 37'd24;
    st_next[0]      = '0;
    st_next[0].hour = m37[36:32];
    st_next[0].res  = m37[31:0];

    for (int k = 1; k < PIPE_DEPTH; k++) begin
      st_next[k] = st[k-1];
    end

    m38 = 38'(st[0].res) * 38'd60;
    st_next[1].minute = m38[37:32];
    st_next[1].res    = m38[31:0];

    m38 = 38'(st[1].res) * 38'd60;
    st_next[2].sec = m38[37:16];
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < PIPE_DEPTH; k++) begin
      if (ctl.en[k]) begin
        st[k] <= st_next[k];
      end
    end
  end

  assign hour_out     = st[PIPE_DEPTH-1].hour;
  assign minute_out   = st[PIPE_DEPTH-1].minute;
  assign second_fixed = st[PIPE_DEPTH-1].sec;

endmodule
`default_nettype wire

FILE: rtl/core/mjd_to_calendar_date_unit.sv
// Converts a Modified Julian Day plus a Q0.32 day fraction into Gregorian year, month,
// day, day of year and truncated hour, minute and second (second in 2^-16 s units).
// Days outside 0001-01-01 to 9999-12-31 set range_error and zero the date fields.
// A 25-stage pipeline takes a request every cycle unless all stages are full and the
// output stalls; each of the five constant divisions of the date chain takes three
// stages (reciprocal multiply, back-multiply, correcting compare). Stages with no
// valid request are filled while the output stalls, so a stalled result blocks the
// input only once all 25 stages hold requests. No state is kept between requests.
`default_nettype none
`include "mjd_to_calendar_date_unit_defines.svh"
module mjd_to_calendar_date_unit
  import mjdcal_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  mjdcal_in_if.sink    request,
  mjdcal_out_if.source result
);

  pipe_ctl_t ctl;

  mjdcal_ctl u_ctl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (request.valid),
    .out_ready (result.ready),
    .ctl       (ctl)
  );

  mjdcal_date u_date (
    .clk          (clk),
    .ctl          (ctl),
    .mjd_day      (request.mjd_day),
    .year_out     (result.year_out),
    .month_out    (result.month_out),
    .day_of_month (result.day_of_month),
    .day_in_year  (result.day_in_year),
    .range_error  (result.range_error)
  );

  mjdcal_tod u_tod (
    .clk          (clk),
    .ctl          (ctl),
    .day_fraction (request.day_fraction),
    .hour_out     (result.hour_out),
    .minute_out   (result.minute_out),
    .second_fixed (result.second_fixed)
  );

  assign request.ready = ctl.en[0] & ~rst;
  assign result.valid  = ctl.valid[PIPE_DEPTH-1];

  `MJDCAL_ASSERT_NOW(a_empty_after_reset, $past(rst), !result.valid)
  `MJDCAL_ASSERT_NOW(a_blocked_only_when_full, !request.ready, (&ctl.valid) && !result.ready)
  `MJDCAL_ASSERT_NEXT(a_fill_tracks_requests, request.valid && request.ready && !(result.valid && result.ready), $countones(ctl.valid) == $past($countones(ctl.valid)) + 1)

endmodule
`default_nettype wire
